// ===== rtl/core/mte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mte_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam int START_BITS   = 24;
    localparam int LENGTH_BITS  = 17;
    localparam int SPACING_BITS = 16;
    localparam int COUNT_BITS   = 5;
    localparam int GAIN_BITS    = 16;
    localparam int FRAME_BITS   = 32;

    localparam int Q_SHIFT = 15;
    localparam logic [GAIN_BITS-1:0] Q_ONE = 16'h8000;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_START  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_SPACING   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_COUNT     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_GAIN    = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_TAP   = 7'b0000100,
        ST_MAC   = 7'b0001000,
        ST_FOLD  = 7'b0010000,
        ST_SCALE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mte_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mte_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mte_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mte_div
    import mte_pkg::*;
#(
    parameter int QW  = 22,
    parameter int DVW = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [QW-1:0]   dividend,
    input  logic [DVW-1:0]  divisor,
    output logic [QW-1:0]   quotient,
    output div_status_t     status
);

    localparam int CW = $clog2(QW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [QW-1:0]  quo_reg, quo_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] dvs_reg, dvs_next;
    logic [DVW:0]   shifted;
    logic [DVW:0]   trial;
    logic           fits;

    assign shifted = {rem_reg, quo_reg[QW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DVW-1:0] : shifted[DVW-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/windowed_multi_tap_echo_top.sv =====
// Windowed multi-tap echo for one mono channel. Each input beat is one PCM sample;
// frames inside the capture window are written to the echo store, and the output beat
// is the dry sample plus up to tap_count decayed reflections, divided by tap_count
// (clamped to 1..MAX_TAPS, truncating) and saturated. One shared multiplier forms the decay
// power and the tap product in two passes per reflection, and a bit-serial divider produces
// the quotient; no new input beat is taken until the output beat for the current one is
// registered. The echo store is not cleared after reset. Write configuration only while
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module windowed_multi_tap_echo_top
    import mte_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int LW  = $clog2(STORE_DEPTH + 1);
    localparam int TW  = $clog2(MAX_TAPS + 1);
    localparam int MAW = (SAMPLE_BITS > GAIN_BITS ? SAMPLE_BITS : GAIN_BITS) + 1;
    localparam int PW  = MAW + GAIN_BITS + 1;
    localparam int PRW = SAMPLE_BITS + GAIN_BITS;
    localparam int ACW = PRW + TW;
    localparam int QW  = ACW - Q_SHIFT;

    localparam logic [QW-1:0] SAT_POS = QW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [QW-1:0] SAT_NEG = QW'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic [START_BITS-1:0]   window_start_reg;
    logic [LENGTH_BITS-1:0]  window_length_reg;
    logic [SPACING_BITS-1:0] tap_spacing_reg;
    logic [COUNT_BITS-1:0]   tap_count_reg;
    logic [GAIN_BITS-1:0]    decay_gain_reg;

    state_t                  state_reg, state_next;
    logic [FRAME_BITS-1:0]   frame_reg, frame_next;
    logic [TW-1:0]           tap_idx_reg, tap_idx_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [FRAME_BITS-1:0]         t_reg, t_next;
    logic signed [ACW-1:0]         acc_reg, acc_next;
    logic [GAIN_BITS-1:0]          p_reg, p_next;
    logic [FRAME_BITS-1:0]         idx_reg, idx_next;
    logic                          neg_reg, neg_next;
    logic signed [PRW-1:0]         prod_reg, prod_next;
    logic                          pend_reg, pend_next;
    logic                          tap_ok_reg, tap_ok_next;
    logic [SAMPLE_BITS-1:0]        out_sample_reg, out_sample_next;

    logic [LW-1:0]           len_eff;
    logic [TW-1:0]           cnt_eff;
    logic [GAIN_BITS-1:0]    g_eff;
    logic                    in_range;
    logic [FRAME_BITS-1:0]   rel;
    logic                    win;
    logic [FRAME_BITS:0]     tap_diff;
    logic                    tap_neg;
    logic                    tap_ok;
    logic signed [ACW-1:0]   acc_init;
    logic signed [ACW-1:0]   prod_ext;
    logic [ACW-1:0]          acc_mag;

    logic signed [MAW-1:0]   mul_a;
    logic [GAIN_BITS-1:0]    mul_b;
    logic signed [PW-1:0]    mul_p;

    logic                    store_we;
    logic                    store_re;
    logic [SAMPLE_BITS-1:0]  store_rdata;

    logic                    div_start;
    logic [QW-1:0]           div_quot;
    div_status_t             div_stat;
    logic [QW-1:0]           q_neg;
    logic [SAMPLE_BITS-1:0]  sat_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg  <= '0;
            window_length_reg <= '0;
            tap_spacing_reg   <= '0;
            tap_count_reg     <= COUNT_BITS'(1);
            decay_gain_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_START:  window_start_reg  <= cfg_data[START_BITS-1:0];
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[LENGTH_BITS-1:0];
                CFG_TAP_SPACING:   tap_spacing_reg   <= cfg_data[SPACING_BITS-1:0];
                CFG_TAP_COUNT:     tap_count_reg     <= cfg_data[COUNT_BITS-1:0];
                CFG_DECAY_GAIN:    decay_gain_reg    <= cfg_data[GAIN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    assign len_eff = (32'(window_length_reg) > 32'(STORE_DEPTH)) ? LW'(STORE_DEPTH)
                                                                 : LW'(window_length_reg);
    assign cnt_eff = (tap_count_reg == '0) ? TW'(1)
                   : (32'(tap_count_reg) > 32'(MAX_TAPS)) ? TW'(MAX_TAPS)
                   : TW'(tap_count_reg);
    assign g_eff   = (decay_gain_reg > Q_ONE) ? Q_ONE : decay_gain_reg;

    assign in_range = t_reg >= FRAME_BITS'(window_start_reg);
    assign rel      = t_reg - FRAME_BITS'(window_start_reg);
    assign win      = in_range && (rel < FRAME_BITS'(len_eff));

    assign tap_diff = {1'b0, idx_reg} - (FRAME_BITS + 1)'(tap_spacing_reg);
    assign tap_neg  = neg_reg | tap_diff[FRAME_BITS];
    assign tap_ok   = !tap_neg && (tap_diff[FRAME_BITS-1:0] < FRAME_BITS'(len_eff));

    assign acc_init = {{(ACW - SAMPLE_BITS - Q_SHIFT){x_reg[SAMPLE_BITS-1]}}, x_reg,
                       {Q_SHIFT{1'b0}}};
    assign prod_ext = {{(ACW - PRW){prod_reg[PRW-1]}}, prod_reg};
    assign acc_mag  = acc_reg[ACW-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);

    assign mul_p = PW'(mul_a) * PW'($signed({1'b0, mul_b}));

    assign q_neg = '0 - div_quot;

    always_comb
    begin
        if (!acc_reg[ACW-1])
        begin
            sat_sample = (div_quot > SAT_POS) ? OUT_MAX : div_quot[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat_sample = (div_quot > SAT_NEG) ? OUT_MIN : q_neg[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        frame_next      = frame_reg;
        tap_idx_next    = tap_idx_reg;
        out_valid_next  = out_valid_reg;
        x_next          = x_reg;
        t_next          = t_reg;
        acc_next        = acc_reg;
        p_next          = p_reg;
        idx_next        = idx_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        pend_next       = pend_reg;
        tap_ok_next     = tap_ok_reg;
        out_sample_next = out_sample_reg;
        store_we        = 1'b0;
        store_re        = 1'b0;
        div_start       = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next = in_sample;
                    t_next = frame_reg;
                    if (frame_reg != '1)
                    begin
                        frame_next = frame_reg + 1'b1;
                    end
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                // capture before any tap reads
                store_we     = win;
                acc_next     = acc_init;
                p_next       = Q_ONE;
                idx_next     = rel;
                neg_next     = !in_range;
                pend_next    = 1'b0;
                tap_idx_next = TW'(1);
                state_next   = ST_TAP;
            end
            ST_TAP:
            begin
                mul_a       = $signed({{(MAW - GAIN_BITS){1'b0}}, p_reg});
                mul_b       = g_eff;
                p_next      = mul_p[Q_SHIFT+GAIN_BITS-1:Q_SHIFT];
                idx_next    = tap_diff[FRAME_BITS-1:0];
                neg_next    = tap_neg;
                tap_ok_next = tap_ok;
                store_re    = tap_ok;
                if (pend_reg)
                begin
                    acc_next = acc_reg + prod_ext;
                end
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                mul_a     = $signed({{(MAW - SAMPLE_BITS){store_rdata[SAMPLE_BITS-1]}},
                                     store_rdata});
                mul_b     = p_reg;
                prod_next = mul_p[PRW-1:0];
                pend_next = tap_ok_reg;
                if (tap_idx_reg == cnt_eff)
                begin
                    state_next = ST_FOLD;
                end
                else
                begin
                    tap_idx_next = tap_idx_reg + 1'b1;
                    state_next   = ST_TAP;
                end
            end
            ST_FOLD:
            begin
                if (pend_reg)
                begin
                    acc_next = acc_reg + prod_ext;
                end
                pend_next  = 1'b0;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                div_start  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the quotient, then for a free output register
                if (div_stat.done || (!div_stat.busy && !div_start))
                begin
                    if (!div_stat.busy && (!out_valid_reg || !out_stall))
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = sat_sample;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_reg     <= '0;
            tap_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            tap_idx_reg   <= tap_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        t_reg          <= t_next;
        acc_reg        <= acc_next;
        p_reg          <= p_next;
        idx_reg        <= idx_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        pend_reg       <= pend_next;
        tap_ok_reg     <= tap_ok_next;
        out_sample_reg <= out_sample_next;
    end

    mte_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW),
        .DW    (SAMPLE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (rel[AW-1:0]),
        .wdata (x_reg),
        .re    (store_re),
        .raddr (tap_diff[AW-1:0]),
        .rdata (store_rdata)
    );

    mte_div #(
        .QW  (QW),
        .DVW (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_mag[ACW-1:Q_SHIFT]),
        .divisor  (cnt_eff),
        .quotient (div_quot),
        .status   (div_stat)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_START))
        else $error("accepted beat did not start an item");

    a_tap_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP || state_reg == ST_MAC)
            |-> (tap_idx_reg != '0 && tap_idx_reg <= cnt_eff))
        else $error("tap index outside tap count");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (p_reg <= Q_ONE))
        else $error("decay power above one");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> (state_reg == ST_DONE))
        else $error("divider active outside the output phase");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("output beat raised outside the output phase");

endmodule

`default_nettype wire
